// ===== sv/sfcs_pkg.sv =====
// Package for the SPI flash command sequencer: phases, operations, codes.
// Used by sfcs_outq, the top level and the testbench; depends on nothing.
`default_nettype none
package sfcs_pkg;

  localparam int PageBytes = 256;
  localparam int BlankPages = 16;
  localparam int BufDepth = 256;
  localparam int BufAw = 8;

  typedef enum logic [3:0] {
    PH_IDLE, PH_WREN, PH_CMD, PH_A2, PH_A1, PH_A0, PH_DATA, PH_PCMD, PH_POLL
  } phase_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_READ, OP_PROGRAM, OP_SCHECK, OP_SECURE, OP_CHIP, OP_SERASE
  } op_t;

  localparam logic [2:0] F_LOAD = 3'd0;
  localparam logic [2:0] F_READ = 3'd1;
  localparam logic [2:0] F_PROG = 3'd2;
  localparam logic [2:0] F_SERASE = 3'd3;
  localparam logic [2:0] F_SECURE = 3'd4;
  localparam logic [2:0] F_CHIP = 3'd5;
  localparam logic [2:0] F_DONE = 3'd6;
  localparam logic [2:0] F_UNUSED = 3'd7;

  localparam logic [1:0] K_XFER = 2'd0;
  localparam logic [1:0] K_REL = 2'd1;
  localparam logic [1:0] K_DATA = 2'd2;
  localparam logic [1:0] K_CMPL = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BLANK = 2'd1;
  localparam logic [1:0] ST_REJ = 2'd2;

  localparam logic [7:0] C_READ = 8'h03;
  localparam logic [7:0] C_WREN = 8'h06;
  localparam logic [7:0] C_PP = 8'h02;
  localparam logic [7:0] C_RDSR = 8'h05;
  localparam logic [7:0] C_SE = 8'h20;
  localparam logic [7:0] C_SECE = 8'h44;
  localparam logic [7:0] C_CE = 8'h60;
  localparam logic [7:0] C_DUMMY = 8'hFF;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic [7:0] read_byte;
    logic [1:0] status;
    logic last;
  } res_t;

  function automatic res_t mk(input logic [1:0] k, input logic [7:0] t,
                              input logic [7:0] r, input logic [1:0] s);
    res_t x;
    x.kind = k;
    x.tx_byte = t;
    x.read_byte = r;
    x.status = s;
    x.last = 1'b0;
    return x;
  endfunction

endpackage
`default_nettype wire

// ===== sv/sfcs_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module sfcs_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/sfcs_outq.sv =====
// Result queue: holds up to four result words of one step.
// Depends on sfcs_pkg.
`default_nettype none
module sfcs_outq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire logic [2:0]     n,
  input  wire sfcs_pkg::res_t r0,
  input  wire sfcs_pkg::res_t r1,
  input  wire sfcs_pkg::res_t r2,
  input  wire sfcs_pkg::res_t r3,
  output logic                empty,
  output logic                valid,
  input  wire logic           stall,
  output sfcs_pkg::res_t      head
);
  import sfcs_pkg::*;

  res_t q [4];
  logic [2:0] cnt;
  logic [1:0] rd;
  logic pop;

  assign valid = cnt != 3'd0;
  assign empty = cnt == 3'd0;
  assign pop = valid && !stall;
  assign head = q[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
      rd <= 2'd0;
    end else if (push) begin
      q[0] <= r0;
      q[1] <= r1;
      q[2] <= r2;
      q[3] <= r3;
      cnt <= n;
      rd <= 2'd0;
    end else if (pop) begin
      cnt <= cnt - 3'd1;
      rd <= rd + 2'd1;
    end
  end
endmodule
`default_nettype wire

// ===== sv/spi_flash_command_sequencer.sv =====
// Top level of the SPI flash command sequencer.
// Depends on sfcs_pkg, sfcs_ram and sfcs_outq.
//
// Usage: the host sends words on the input channel (valid/stall): buffer
// loads, requests, and "exchange done" words that carry the byte received
// from the flash. Each input word produces zero to three result words on the
// output channel (valid/stall), the last one flagged by last.
// A word taken at a clock edge is worked on in the next cycle, and its first
// result is offered in the cycle after that.
// The next word is taken at the edge where the last result of the previous
// word leaves, or as soon as the queue is empty.
// The program buffer is a 256-byte RAM read one position ahead.
// A stalled output holds its word and blocks new input words.
// Reset returns the sequencer to idle with chip select released; the
// buffer contents are undefined until loaded.
`default_nettype none
module spi_flash_command_sequencer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  func,
  input  wire logic [23:0] address,
  input  wire logic [15:0] length,
  input  wire logic [7:0]  buffer_index,
  input  wire logic [7:0]  data_byte,
  input  wire logic [3:0]  register_number,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic [7:0]       tx_byte,
  output logic [7:0]       read_byte,
  output logic [1:0]       status,
  output logic             last
);
  import sfcs_pkg::*;

  phase_t phase, phase_next;
  op_t operation, operation_next;
  logic [23:0] cur_addr, cur_addr_next, sec_start, sec_start_next;
  logic [15:0] bytes_rem, bytes_rem_next;
  logic [8:0] chunk_rem, chunk_rem_next;
  logic [7:0] buf_pos, buf_pos_next;
  logic [4:0] pages, pages_next;
  logic not_blank, not_blank_next, sel, sel_next;

  logic busy;
  logic [2:0] s_func;
  logic [23:0] s_addr;
  logic [15:0] s_len;
  logic [3:0] s_reg;
  logic [7:0] s_rx;
  logic q_empty, acc, push;
  logic [7:0] rdata;
  logic [BufAw-1:0] raddr;
  res_t r [4];
  res_t head;
  logic [2:0] n;

  assign acc = in_valid && !in_stall;
  assign in_stall = busy || (!q_empty && !(out_valid && !out_stall && last));

  // In the data phase the next buffer position is read, so data is ready on the step.
  assign raddr = (phase == PH_DATA) ? buf_pos + 8'd1 : buf_pos;

  sfcs_ram #(.Width(8), .Depth(BufDepth)) u_buf (
    .clk(clk),
    .we(acc && func == F_LOAD && phase == PH_IDLE),
    .waddr(buffer_index), .wdata(data_byte),
    .raddr(raddr), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) busy <= 1'b0;
    else busy <= acc;
    if (acc) begin
      s_func <= func;
      s_addr <= address;
      s_len <= length;
      s_reg <= register_number;
      s_rx <= rx_byte;
    end
  end
  assign push = busy;

  function automatic logic [8:0] chunk(input logic [23:0] a, input logic [15:0] b);
    logic [8:0] room;
    room = 9'(PageBytes) - {1'b0, a[7:0]};
    return ({7'd0, room} < b) ? room : b[8:0];
  endfunction

  always_comb begin
    logic [15:0] left;
    logic done;
    phase_next = phase;
    operation_next = operation;
    cur_addr_next = cur_addr;
    sec_start_next = sec_start;
    bytes_rem_next = bytes_rem;
    chunk_rem_next = chunk_rem;
    buf_pos_next = buf_pos;
    pages_next = pages;
    not_blank_next = not_blank;
    sel_next = sel;
    for (int i = 0; i < 4; i++) r[i] = mk(K_XFER, 8'd0, 8'd0, ST_OK);
    n = 3'd0;
    left = 16'd0;
    done = 1'b0;
    if (busy) begin
      if (s_func == F_DONE) begin
        done = 1'b0;
        unique case (phase)
          PH_WREN: begin
            r[0] = mk(K_REL, 8'd0, 8'd0, ST_OK);
            r[1] = mk(K_XFER, operation == OP_PROGRAM ? C_PP :
                      operation == OP_SERASE ? C_SE :
                      operation == OP_SECURE ? C_SECE : C_CE, 8'd0, ST_OK);
            n = 3'd2;
            phase_next = PH_CMD;
          end
          PH_CMD: begin
            if (operation == OP_CHIP) begin
              r[0] = mk(K_REL, 8'd0, 8'd0, ST_OK);
              r[1] = mk(K_XFER, C_RDSR, 8'd0, ST_OK);
              n = 3'd2;
              phase_next = PH_PCMD;
            end else begin
              r[0] = mk(K_XFER, cur_addr[23:16], 8'd0, ST_OK);
              n = 3'd1;
              phase_next = PH_A2;
            end
          end
          PH_A2: begin
            r[0] = mk(K_XFER, cur_addr[15:8], 8'd0, ST_OK);
            n = 3'd1;
            phase_next = PH_A1;
          end
          PH_A1: begin
            r[0] = mk(K_XFER, cur_addr[7:0], 8'd0, ST_OK);
            n = 3'd1;
            phase_next = PH_A0;
          end
          PH_A0: begin
            if (operation == OP_SERASE || operation == OP_SECURE) begin
              r[0] = mk(K_REL, 8'd0, 8'd0, ST_OK);
              r[1] = mk(K_XFER, C_RDSR, 8'd0, ST_OK);
              n = 3'd2;
              phase_next = PH_PCMD;
            end else begin
              done = 1'b1;
            end
          end
          PH_DATA: begin
            if (operation == OP_READ) begin
              r[0] = mk(K_DATA, 8'd0, s_rx, ST_OK);
              n = 3'd1;
            end else if (operation == OP_SCHECK) begin
              if (s_rx != 8'hFF) not_blank_next = 1'b1;
            end else begin
              buf_pos_next = buf_pos + 8'd1;
              cur_addr_next = cur_addr + 24'd1;
              chunk_rem_next = chunk_rem - 9'd1;
            end
            bytes_rem_next = bytes_rem - 16'd1;
            done = 1'b1;
          end
          PH_PCMD: begin
            r[0] = mk(K_XFER, C_DUMMY, 8'd0, ST_OK);
            n = 3'd1;
            phase_next = PH_POLL;
          end
          PH_POLL: begin
            if (s_rx[0]) begin
              r[0] = mk(K_XFER, C_DUMMY, 8'd0, ST_OK);
              n = 3'd1;
            end else begin
              r[0] = mk(K_REL, 8'd0, 8'd0, ST_OK);
              n = 3'd2;
              if (operation == OP_PROGRAM && bytes_rem != 16'd0) begin
                chunk_rem_next = chunk(cur_addr, bytes_rem);
                r[1] = mk(K_XFER, C_WREN, 8'd0, ST_OK);
                phase_next = PH_WREN;
              end else begin
                r[1] = mk(K_CMPL, 8'd0, 8'd0, ST_OK);
                phase_next = PH_IDLE;
                operation_next = OP_NONE;
              end
            end
          end
          default: n = 3'd0;
        endcase
        // Data byte or end of a data frame, shared by address and data phases.
        if (done) begin
          left = (operation == OP_PROGRAM) ? {7'd0, chunk_rem_next} : bytes_rem_next;
          if (left != 16'd0) begin
            r[n[1:0]] = mk(K_XFER, operation == OP_PROGRAM ? rdata : C_DUMMY,
                           8'd0, ST_OK);
            n = n + 3'd1;
            phase_next = PH_DATA;
          end else begin
            r[n[1:0]] = mk(K_REL, 8'd0, 8'd0, ST_OK);
            n = n + 3'd1;
            if (operation == OP_READ) begin
              r[n[1:0]] = mk(K_CMPL, 8'd0, 8'd0, ST_OK);
              n = n + 3'd1;
              phase_next = PH_IDLE;
              operation_next = OP_NONE;
            end else if (operation == OP_SCHECK) begin
              cur_addr_next = cur_addr + 24'(PageBytes);
              pages_next = pages + 5'd1;
              if (not_blank_next) begin
                operation_next = OP_SERASE;
                cur_addr_next = sec_start;
                r[n[1:0]] = mk(K_XFER, C_WREN, 8'd0, ST_OK);
                n = n + 3'd1;
                phase_next = PH_WREN;
              end else if (pages_next >= 5'(BlankPages)) begin
                r[n[1:0]] = mk(K_CMPL, 8'd0, 8'd0, ST_BLANK);
                n = n + 3'd1;
                phase_next = PH_IDLE;
                operation_next = OP_NONE;
              end else begin
                bytes_rem_next = 16'(PageBytes);
                r[n[1:0]] = mk(K_XFER, C_READ, 8'd0, ST_OK);
                n = n + 3'd1;
                phase_next = PH_CMD;
              end
            end else begin
              r[n[1:0]] = mk(K_XFER, C_RDSR, 8'd0, ST_OK);
              n = n + 3'd1;
              phase_next = PH_PCMD;
            end
          end
        end
      end else if (s_func == F_UNUSED || phase != PH_IDLE) begin
        r[0] = mk(K_CMPL, 8'd0, 8'd0, ST_REJ);
        n = 3'd1;
      end else begin
        n = 3'd1;
        unique case (s_func)
          F_LOAD: r[0] = mk(K_CMPL, 8'd0, 8'd0, ST_OK);
          F_READ: begin
            operation_next = OP_READ;
            cur_addr_next = s_addr;
            bytes_rem_next = s_len;
            r[0] = mk(K_XFER, C_READ, 8'd0, ST_OK);
            phase_next = PH_CMD;
          end
          F_PROG: begin
            if (s_len > 16'(BufDepth)) begin
              r[0] = mk(K_CMPL, 8'd0, 8'd0, ST_REJ);
            end else if (s_len == 16'd0) begin
              r[0] = mk(K_CMPL, 8'd0, 8'd0, ST_OK);
            end else begin
              operation_next = OP_PROGRAM;
              cur_addr_next = s_addr;
              bytes_rem_next = s_len;
              buf_pos_next = 8'd0;
              chunk_rem_next = chunk(s_addr, s_len);
              r[0] = mk(K_XFER, C_WREN, 8'd0, ST_OK);
              phase_next = PH_WREN;
            end
          end
          F_SERASE: begin
            operation_next = OP_SCHECK;
            sec_start_next = s_addr;
            cur_addr_next = s_addr;
            pages_next = 5'd0;
            not_blank_next = 1'b0;
            bytes_rem_next = 16'(PageBytes);
            r[0] = mk(K_XFER, C_READ, 8'd0, ST_OK);
            phase_next = PH_CMD;
          end
          F_SECURE: begin
            operation_next = OP_SECURE;
            cur_addr_next = {8'd0, s_reg, 12'd0};
            r[0] = mk(K_XFER, C_WREN, 8'd0, ST_OK);
            phase_next = PH_WREN;
          end
          default: begin
            operation_next = OP_CHIP;
            r[0] = mk(K_XFER, C_WREN, 8'd0, ST_OK);
            phase_next = PH_WREN;
          end
        endcase
      end
      for (int i = 0; i < 4; i++) begin
        if (r[i].kind == K_XFER && 3'(i) < n) sel_next = 1'b1;
        if (r[i].kind == K_REL && 3'(i) < n) sel_next = 1'b0;
      end
      if (n != 3'd0) r[n[1:0] - 2'd1].last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      operation <= OP_NONE;
      cur_addr <= 24'd0;
      sec_start <= 24'd0;
      bytes_rem <= 16'd0;
      chunk_rem <= 9'd0;
      buf_pos <= 8'd0;
      pages <= 5'd0;
      not_blank <= 1'b0;
      sel <= 1'b0;
    end else begin
      phase <= phase_next;
      operation <= operation_next;
      cur_addr <= cur_addr_next;
      sec_start <= sec_start_next;
      bytes_rem <= bytes_rem_next;
      chunk_rem <= chunk_rem_next;
      buf_pos <= buf_pos_next;
      pages <= pages_next;
      not_blank <= not_blank_next;
      sel <= sel_next;
    end
  end

  sfcs_outq u_q (
    .clk(clk), .rst(rst), .push(push), .n(n),
    .r0(r[0]), .r1(r[1]), .r2(r[2]), .r3(r[3]),
    .empty(q_empty), .valid(out_valid), .stall(out_stall), .head(head)
  );

  assign kind = head.kind;
  assign tx_byte = head.tx_byte;
  assign read_byte = head.read_byte;
  assign status = head.status;
  assign last = head.last;

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !acc) else $error("input taken while a word is in work");
  a_idle_released: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> !sel) else $error("chip select held while idle");
  a_idle_no_op: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (operation == OP_NONE)) else $error("idle with operation");
`endif
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Testbench for the SPI flash command sequencer: directed table, then random requests
// with random received bytes, checked word by word against the table or an in-bench predictor.
// Depends on sfcs_pkg and spi_flash_command_sequencer.
`timescale 1ns / 1ps
module tb_top;
  import sfcs_pkg::*;

  localparam int CycleLimit = 3000000;
  localparam int RandomWords = 250;

  typedef struct {
    logic [2:0]  func;
    logic [23:0] address;
    logic [15:0] length;
    logic [7:0]  index;
    logic [7:0]  data;
    logic [3:0]  regno;
    logic [7:0]  rx;
  } req_t;

  typedef struct {
    req_t w;
    bit   typed;
    res_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] func = '0;
  logic [23:0] address = '0;
  logic [15:0] length = '0;
  logic [7:0] buffer_index = '0;
  logic [7:0] data_byte = '0;
  logic [3:0] register_number = '0;
  logic [7:0] rx_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] kind;
  logic [7:0] tx_byte;
  logic [7:0] read_byte;
  logic [1:0] status;
  logic last;

  spi_flash_command_sequencer dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .func(func),
    .address(address), .length(length), .buffer_index(buffer_index),
    .data_byte(data_byte), .register_number(register_number), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind), .tx_byte(tx_byte),
    .read_byte(read_byte), .status(status), .last(last)
  );

  always #1 clk = ~clk;

  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned words_out = 0;
  res_t pending_words[$];
  res_t step_words[$];

  phase_t seq_phase;
  op_t seq_op;
  logic [23:0] cur_addr;
  logic [23:0] sector_base;
  int unsigned remain;
  int unsigned chunk;
  logic [7:0] buf_pos;
  logic [7:0] page_buf [BufDepth];
  int unsigned pages_done;
  bit not_blank;

  function automatic void put(logic [1:0] k, logic [7:0] t, logic [7:0] r, logic [1:0] s);
    res_t x;
    x.kind = k;
    x.tx_byte = t;
    x.read_byte = r;
    x.status = s;
    x.last = 1'b0;
    step_words.push_back(x);
  endfunction

  function automatic void shift_out(phase_t p, logic [7:0] t);
    seq_phase = p;
    put(K_XFER, t, 8'h00, ST_OK);
  endfunction

  function automatic void release_cs();
    put(K_REL, 8'h00, 8'h00, ST_OK);
  endfunction

  function automatic void complete(logic [1:0] s);
    seq_phase = PH_IDLE;
    seq_op = OP_NONE;
    put(K_CMPL, 8'h00, 8'h00, s);
  endfunction

  function automatic void page_chunk();
    int unsigned room;
    room = PageBytes - (cur_addr % PageBytes);
    chunk = (room < remain) ? room : remain;
  endfunction

  function automatic int unsigned bytes_left();
    return (seq_op == OP_PROGRAM) ? chunk : remain;
  endfunction

  function automatic void next_data();
    shift_out(PH_DATA, (seq_op == OP_PROGRAM) ? page_buf[buf_pos] : C_DUMMY);
  endfunction

  function automatic void close_frame();
    release_cs();
    if (seq_op == OP_READ) begin
      complete(ST_OK);
    end else if (seq_op == OP_SCHECK) begin
      cur_addr = cur_addr + 24'(PageBytes);
      pages_done++;
      if (not_blank) begin
        seq_op = OP_SERASE;
        cur_addr = sector_base;
        shift_out(PH_WREN, C_WREN);
      end else if (pages_done >= BlankPages) begin
        complete(ST_BLANK);
      end else begin
        remain = PageBytes;
        shift_out(PH_CMD, C_READ);
      end
    end else begin
      shift_out(PH_PCMD, C_RDSR);
    end
  endfunction

  function automatic void exchange(logic [7:0] rx);
    case (seq_phase)
      PH_WREN: begin
        release_cs();
        case (seq_op)
          OP_PROGRAM: shift_out(PH_CMD, C_PP);
          OP_SERASE: shift_out(PH_CMD, C_SE);
          OP_SECURE: shift_out(PH_CMD, C_SECE);
          default: shift_out(PH_CMD, C_CE);
        endcase
      end
      PH_CMD: begin
        if (seq_op == OP_CHIP) begin
          release_cs();
          shift_out(PH_PCMD, C_RDSR);
        end else begin
          shift_out(PH_A2, cur_addr[23:16]);
        end
      end
      PH_A2: shift_out(PH_A1, cur_addr[15:8]);
      PH_A1: shift_out(PH_A0, cur_addr[7:0]);
      PH_A0: begin
        if (seq_op == OP_SERASE || seq_op == OP_SECURE) begin
          release_cs();
          shift_out(PH_PCMD, C_RDSR);
        end else if (bytes_left() > 0) begin
          next_data();
        end else begin
          close_frame();
        end
      end
      PH_DATA: begin
        if (seq_op == OP_READ) begin
          put(K_DATA, 8'h00, rx, ST_OK);
        end else if (seq_op == OP_SCHECK) begin
          if (rx != 8'hFF) not_blank = 1'b1;
        end else begin
          buf_pos++;
          cur_addr++;
          chunk--;
        end
        remain--;
        if (bytes_left() > 0) next_data();
        else close_frame();
      end
      PH_PCMD: shift_out(PH_POLL, C_DUMMY);
      PH_POLL: begin
        if (rx[0]) begin
          shift_out(PH_POLL, C_DUMMY);
        end else begin
          release_cs();
          if (seq_op == OP_PROGRAM && remain > 0) begin
            page_chunk();
            shift_out(PH_WREN, C_WREN);
          end else begin
            complete(ST_OK);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void predict(req_t w);
    step_words.delete();
    if (w.func == F_DONE) begin
      if (seq_phase != PH_IDLE) exchange(w.rx);
    end else if (w.func == F_UNUSED || seq_phase != PH_IDLE) begin
      put(K_CMPL, 8'h00, 8'h00, ST_REJ);
    end else begin
      case (w.func)
        F_LOAD: begin
          page_buf[w.index] = w.data;
          put(K_CMPL, 8'h00, 8'h00, ST_OK);
        end
        F_READ: begin
          seq_op = OP_READ;
          cur_addr = w.address;
          remain = w.length;
          shift_out(PH_CMD, C_READ);
        end
        F_PROG: begin
          if (w.length > BufDepth) begin
            put(K_CMPL, 8'h00, 8'h00, ST_REJ);
          end else if (w.length == 0) begin
            put(K_CMPL, 8'h00, 8'h00, ST_OK);
          end else begin
            seq_op = OP_PROGRAM;
            cur_addr = w.address;
            remain = w.length;
            buf_pos = 8'h00;
            page_chunk();
            shift_out(PH_WREN, C_WREN);
          end
        end
        F_SERASE: begin
          seq_op = OP_SCHECK;
          sector_base = w.address;
          cur_addr = w.address;
          pages_done = 0;
          not_blank = 1'b0;
          remain = PageBytes;
          shift_out(PH_CMD, C_READ);
        end
        F_SECURE: begin
          seq_op = OP_SECURE;
          cur_addr = {8'h00, w.regno, 12'h000};
          shift_out(PH_WREN, C_WREN);
        end
        default: begin
          seq_op = OP_CHIP;
          shift_out(PH_WREN, C_WREN);
        end
      endcase
    end
    if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
  endfunction

  function automatic req_t mkreq(logic [2:0] f, logic [23:0] a, logic [15:0] l,
                                 logic [7:0] i, logic [7:0] d, logic [3:0] r,
                                 logic [7:0] x);
    req_t w;
    w.func = f;
    w.address = a;
    w.length = l;
    w.index = i;
    w.data = d;
    w.regno = r;
    w.rx = x;
    return w;
  endfunction

  function automatic row_t mkrow(req_t w, bit typed, logic [1:0] k, logic [7:0] t,
                                 logic [1:0] s);
    row_t r;
    r.w = w;
    r.typed = typed;
    r.want.kind = k;
    r.want.tx_byte = t;
    r.want.read_byte = 8'h00;
    r.want.status = s;
    r.want.last = 1'b1;
    return r;
  endfunction

  function automatic row_t done_row(logic [7:0] x);
    return mkrow(mkreq(F_DONE, 24'h0, 16'h0, 8'h0, 8'h0, 4'h0, x), 1'b0, K_XFER, 8'h0, ST_OK);
  endfunction

  task automatic send_word(req_t w, bit typed, res_t want, int unsigned gap);
    func <= w.func;
    address <= w.address;
    length <= w.length;
    buffer_index <= w.index;
    data_byte <= w.data;
    register_number <= w.regno;
    rx_byte <= w.rx;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict(w);
    if (typed) pending_words.push_back(want);
    else foreach (step_words[i]) pending_words.push_back(step_words[i]);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic int unsigned draw_gap(int unsigned n);
    return ((n / 40) % 3 == 1) ? 0 : $urandom_range(14);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      words_out <= words_out + 1;
      if (pending_words.size() == 0) begin
        $error("unexpected word: kind %0d tx_byte %0h", kind, tx_byte);
        errors++;
      end else begin
        res_t e;
        e = pending_words.pop_front();
        if (kind !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, kind);
          errors++;
        end
        if (tx_byte !== e.tx_byte) begin
          $error("tx_byte: expected %0h, got %0h", e.tx_byte, tx_byte);
          errors++;
        end
        if (read_byte !== e.read_byte) begin
          $error("read_byte: expected %0h, got %0h", e.read_byte, read_byte);
          errors++;
        end
        if (status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status);
          errors++;
        end
        if (last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, last);
          errors++;
        end
      end
    end
  end

  initial begin
    int unsigned g;
    bit held;
    held = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        g = draw_gap(words_out);
        if (!held && words_out >= 80) begin
          g = 300;
          held = 1'b1;
        end
        if (g > 0) begin
          out_stall <= 1'b1;
          repeat (g) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin
    row_t rows[$];
    req_t w;
    res_t none;
    int unsigned n;
    int unsigned loaded;
    int unsigned pick;
    bit blank_sector;
    bit blank_done;

    seq_phase = PH_IDLE;
    seq_op = OP_NONE;
    cur_addr = '0;
    sector_base = '0;
    remain = 0;
    chunk = 0;
    buf_pos = '0;
    pages_done = 0;
    not_blank = 1'b0;
    none = '0;
    loaded = 1;
    blank_sector = 1'b0;
    blank_done = 1'b0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rows.push_back(mkrow(mkreq(F_LOAD, 24'h0, 16'h0, 8'h00, 8'hA5, 4'h0, 8'h0),
                         1'b1, K_CMPL, 8'h00, ST_OK));
    rows.push_back(mkrow(mkreq(F_LOAD, 24'hFFFFFF, 16'hFFFF, 8'hFF, 8'h5A, 4'hF, 8'hFF),
                         1'b1, K_CMPL, 8'h00, ST_OK));
    rows.push_back(mkrow(mkreq(F_UNUSED, 24'h0, 16'h0, 8'h0, 8'h0, 4'h0, 8'h0),
                         1'b1, K_CMPL, 8'h00, ST_REJ));
    rows.push_back(mkrow(mkreq(F_PROG, 24'h0, 16'hFFFF, 8'h0, 8'h0, 4'h0, 8'h0),
                         1'b1, K_CMPL, 8'h00, ST_REJ));
    rows.push_back(mkrow(mkreq(F_PROG, 24'h0, 16'h0, 8'h0, 8'h0, 4'h0, 8'h0),
                         1'b1, K_CMPL, 8'h00, ST_OK));
    rows.push_back(done_row(8'hFF));
    rows.push_back(mkrow(mkreq(F_READ, 24'hFFFFFF, 16'd2, 8'h0, 8'h0, 4'h0, 8'h0),
                         1'b1, K_XFER, C_READ, ST_OK));
    repeat (4) rows.push_back(done_row(8'h00));
    rows.push_back(done_row(8'h00));
    rows.push_back(done_row(8'hFF));
    rows.push_back(mkrow(mkreq(F_CHIP, 24'h0, 16'h0, 8'h0, 8'h0, 4'h0, 8'h0),
                         1'b1, K_XFER, C_WREN, ST_OK));
    rows.push_back(done_row(8'h00));
    rows.push_back(mkrow(mkreq(F_READ, 24'h0, 16'h1, 8'h0, 8'h0, 4'h0, 8'h0),
                         1'b1, K_CMPL, 8'h00, ST_REJ));
    rows.push_back(done_row(8'h00));
    rows.push_back(done_row(8'h00));
    rows.push_back(done_row(8'h01));
    rows.push_back(done_row(8'h00));
    rows.push_back(mkrow(mkreq(F_SECURE, 24'h0, 16'h0, 8'h0, 8'h0, 4'hF, 8'h0),
                         1'b1, K_XFER, C_WREN, ST_OK));
    repeat (6) rows.push_back(done_row(8'h00));
    rows.push_back(done_row(8'h00));

    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].want, draw_gap(i));

    n = 0;
    while (n < RandomWords || seq_phase != PH_IDLE) begin
      w = mkreq(F_DONE, 24'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                4'($urandom), 8'($urandom));
      if (seq_phase != PH_IDLE) begin
        if ($urandom_range(19) == 0) begin
          w.func = $urandom_range(1) ? F_UNUSED : 3'($urandom_range(5));
        end else if (seq_phase == PH_DATA && seq_op == OP_SCHECK) begin
          w.rx = (blank_sector || $urandom_range(7) != 0) ? 8'hFF : 8'($urandom);
        end
      end else begin
        pick = $urandom_range(99);
        if (pick < 30) begin
          w.func = F_LOAD;
          if (loaded < BufDepth && $urandom_range(3) != 0) begin
            w.index = 8'(loaded);
            loaded++;
          end else begin
            w.index = 8'($urandom_range(loaded - 1));
          end
        end else if (pick < 50) begin
          w.func = F_READ;
          w.length = ($urandom_range(9) == 0) ? 16'($urandom_range(300)) :
                                                16'($urandom_range(6));
        end else if (pick < 72) begin
          w.func = F_PROG;
          case ($urandom_range(9))
            0: w.length = 16'(loaded);
            1: w.length = 16'($urandom_range(65535, BufDepth + 1));
            default: w.length = 16'($urandom_range((loaded < 12) ? loaded : 12));
          endcase
        end else if (pick < 75) begin
          w.func = F_SERASE;
          blank_sector = !blank_done && $urandom_range(3) == 0;
          if (blank_sector) blank_done = 1'b1;
        end else if (pick < 84) begin
          w.func = F_SECURE;
        end else if (pick < 93) begin
          w.func = F_CHIP;
        end else if (pick < 97) begin
          w.func = F_UNUSED;
        end
      end
      if (!(w.func == F_DONE && seq_phase == PH_IDLE)) n++;
      send_word(w, 1'b0, none, draw_gap(n));
    end
    in_valid <= 1'b0;

    while (pending_words.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
